// ----- design/pgd_pkg.sv -----
// Shared types and constants of the periodic grid derivative block.
// No dependencies; the multiplier, divider, top level and checker refer to it by scoped names.
package pgd_pkg;

	// Configuration register indexes
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_NUM_POINTS     = 3'd0;
	localparam logic [CFG_IW-1:0] REG_NUM_COMPONENTS = 3'd1;
	localparam logic [CFG_IW-1:0] REG_DIFFUSION_MASK = 3'd2;
	localparam logic [CFG_IW-1:0] REG_SPACING_MODE   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_UNIFORM_STEP   = 3'd4;

	// Magnitude width of products, numerators and divisors
	localparam int MW = 100;
	// Multiplier operand width (spacing magnitudes and sample differences)
	localparam int YW = 34;

	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] coordinate;
		logic signed [31:0] sample;
	} in_t;

	typedef struct packed {
		logic [11:0]        point_index;
		logic [3:0]         column;
		logic signed [31:0] value;
		logic               is_derivative;
		logic               saturated;
		logic               last_of_run;
	} out_t;

	function automatic logic [YW-1:0] mag(input logic signed [YW-1:0] v);
		logic signed [YW-1:0] nv;
		nv = -v;
		return v[YW-1] ? nv : v;
	endfunction

endpackage

// ----- design/pgd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/pgd_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pgd_pkg for operand widths.
module pgd_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pgd_pkg::MW-1:0]   x,
	input  logic [pgd_pkg::YW-1:0]   y,
	output logic                     done,
	output logic [pgd_pkg::MW-1:0]   prod
);

	localparam int CNTW = $clog2(pgd_pkg::YW);

	logic                   busy_q;
	logic                   done_q;
	logic [CNTW-1:0]        cnt_q;
	logic [pgd_pkg::MW-1:0] x_q;
	logic [pgd_pkg::YW-1:0] y_q;
	logic [pgd_pkg::MW-1:0] p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(pgd_pkg::YW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			p_q <= '0;
		end else if (busy_q) begin
			if (y_q[0]) begin
				p_q <= p_q + x_q;
			end
			x_q <= x_q << 1;
			y_q <= y_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

// ----- design/pgd_div.sv -----
// Restoring divider, one quotient bit per cycle, then a rounding step
// (half away from zero on magnitudes). Depends on pgd_pkg for widths.
module pgd_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pgd_pkg::MW-1:0]              num,
	input  logic [pgd_pkg::MW-1:0]              den,
	output logic                                done,
	output logic [pgd_pkg::MW+FRAC_BITS-1:0]    quo
);

	localparam int MW   = pgd_pkg::MW;
	localparam int L    = MW + FRAC_BITS;
	localparam int CNTW = $clog2(L);

	logic            busy_q;
	logic            rnd_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [L-1:0]    rq_q;
	logic [MW-1:0]   r_q;
	logic [MW-1:0]   d_q;

	logic [MW:0] rs;
	logic [MW:0] rdiff;
	logic        ge;
	logic        rnd_up;

	always_comb begin
		rs     = {r_q, rq_q[L-1]};
		rdiff  = rs - {1'b0, d_q};
		ge     = rs >= {1'b0, d_q};
		rnd_up = {r_q, 1'b0} >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(L - 1)) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rq_q <= {num, {FRAC_BITS{1'b0}}};
			r_q  <= '0;
			d_q  <= den;
		end else if (busy_q) begin
			r_q  <= ge ? rdiff[MW-1:0] : rs[MW-1:0];
			rq_q <= {rq_q[L-2:0], ge};
		end else if (rnd_q && rnd_up) begin
			rq_q <= rq_q + L'(1);
		end
	end

	assign done = done_q;
	assign quo  = rq_q;

endmodule

// ----- design/periodic_grid_derivative.sv -----
// Periodic grid derivative: takes one sample beat per cycle while idle and no
// config write is offered; the beat that completes point 2 or a later point
// starts row emission and drops ready until the step's results are out. A
// copied column passes through the read, capture and emit states. In spacing
// mode 1 a derivative uses the 116-bit restoring divider, one bit a cycle,
// then a rounding step. In coordinate mode each row first forms four spacing
// products in the bit-serial multiplier, and each derivative adds two more
// multiplier products before the divide. Samples sit in one RAM of
// 5*MAX_COMPONENTS words (three rotating window rows plus points 0 and 1).
module periodic_grid_derivative #(
	parameter int MAX_COMPONENTS = 8,
	parameter int MAX_POINTS     = 4096,
	parameter int FRAC_BITS      = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pgd_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pgd_pkg::out_t                   out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pgd_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [31:0]                     cfg_data
);

	localparam int MW    = pgd_pkg::MW;
	localparam int YW    = pgd_pkg::YW;
	localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int PW    = $clog2(MAX_POINTS);
	localparam int DEPTH = 5 * MAX_COMPONENTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = MW + FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_ROW, S_MS, S_MW, S_RDC, S_GETC, S_EMC,
		S_RDA, S_RDN, S_GETN, S_DS, S_DW, S_EMD
	} state_t;

	typedef enum logic [2:0] {
		OP_HS2, OP_HD2, OP_T, OP_D, OP_M1, OP_M2
	} op_t;

	typedef enum logic [1:0] {
		K_REG, K_LAST, K_ZERO
	} kind_t;

	function automatic logic [AW-1:0] addr_of(input logic [2:0] s, input logic [CW-1:0] k);
		return AW'(s) * AW'(MAX_COMPONENTS) + AW'(k);
	endfunction

	state_t state_q;
	op_t    op_q;
	kind_t  kind_q;

	// configuration
	logic [12:0] np_q;
	logic [3:0]  nc_q;
	logic [7:0]  mask_q;
	logic        mode_q;
	logic [30:0] step_q;

	// grid position and window bookkeeping
	logic [PW-1:0]      p_q;
	logic [PW-1:0]      pbase_q;
	logic [CW-1:0]      c_q;
	logic               lastpt_q;
	logic [1:0]         rot_q;
	logic [2:0]         sp2_q, sp1_q, scur_q;
	logic signed [31:0] wc0_q, wc1_q, wc2_q, fc0_q, fc1_q;

	// row datapath
	logic [CW-1:0]      j_q;
	logic [3:0]         col_q;
	logic signed [32:0] hs_q, hd_q;
	logic [MW-1:0]      hs2_q, hd2_q, dmag_q;
	logic               dneg_q, nneg_q, nzero_q, dz_q;
	logic signed [31:0] a_q, b_q, nx_q;
	logic signed [MW:0] n_q;

	logic          out_valid_q;
	pgd_pkg::out_t out_q;

	// shared units
	logic          mul_start, mul_done;
	logic [MW-1:0] mul_x, mul_prod;
	logic [YW-1:0] mul_y;
	logic          div_start, div_done;
	logic [MW-1:0] nabs;
	logic [QW-1:0] quo;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;

	// combinational helpers
	logic [3:0]         nc_eff;
	logic [16:0]        npx, np_eff;
	logic               lastpt, comp_last_in, j_last, mbit, row_final, out_free;
	logic               in_acc, emit;
	logic [2:0]         newslot, wslot, ps, cs, ns;
	logic [7:0]         msh;
	logic [PW-1:0]      row_pt;
	logic signed [32:0] hs_n, hd_n, ba, cb, ca;
	logic signed [33:0] hsd;
	logic signed [MW:0] mext, nneg_v;
	logic               dneg_flag, dsat;
	logic [31:0]        dval, qlo;
	logic [32:0]        lim;

	always_comb begin
		nc_eff = (nc_q == 4'd0) ? 4'd1 :
			((nc_q > 4'(MAX_COMPONENTS)) ? 4'(MAX_COMPONENTS) : nc_q);
		npx    = 17'(np_q);
		np_eff = (npx < 17'd3) ? 17'd3 : ((npx > 17'(MAX_POINTS)) ? 17'(MAX_POINTS) : npx);
		lastpt       = 17'(p_q) == (np_eff - 17'd1);
		comp_last_in = (5'(c_q) + 5'd1) == 5'(nc_eff);
		j_last       = (5'(j_q) + 5'd1) == 5'(nc_eff);
		msh          = mask_q >> j_q;
		mbit         = msh[0];
		row_final    = (kind_q == K_ZERO) || ((kind_q == K_REG) && !lastpt_q);
		out_free     = !out_valid_q || out_ready;
		in_acc       = in_valid && in_ready;
		emit         = out_free && ((state_q == S_EMC) || (state_q == S_EMD));

		if (p_q == PW'(0)) begin
			newslot = 3'd3;
		end else if (p_q == PW'(1)) begin
			newslot = 3'd4;
		end else begin
			newslot = {1'b0, rot_q};
		end
		wslot = (c_q == '0) ? newslot : scur_q;

		case (kind_q)
			K_LAST: begin
				ps = sp1_q; cs = scur_q; ns = 3'd3; row_pt = pbase_q;
			end
			K_ZERO: begin
				ps = scur_q; cs = 3'd3; ns = 3'd4; row_pt = '0;
			end
			default: begin
				ps = sp2_q; cs = sp1_q; ns = scur_q; row_pt = pbase_q - PW'(1);
			end
		endcase

		case (state_q)
			S_RDA:   ram_raddr = addr_of(ps, j_q);
			S_RDN:   ram_raddr = addr_of(ns, j_q);
			default: ram_raddr = addr_of(cs, j_q);
		endcase
		ram_we    = in_acc;
		ram_waddr = addr_of(wslot, c_q);

		if (kind_q == K_REG) begin
			hs_n = $signed({wc1_q[31], wc1_q}) - $signed({wc0_q[31], wc0_q});
			hd_n = $signed({wc2_q[31], wc2_q}) - $signed({wc1_q[31], wc1_q});
		end else begin
			hs_n = $signed({wc2_q[31], wc2_q}) - $signed({wc1_q[31], wc1_q});
			hd_n = $signed({fc1_q[31], fc1_q}) - $signed({fc0_q[31], fc0_q});
		end
		hsd = $signed({hs_q[32], hs_q}) + $signed({hd_q[32], hd_q});
		ba  = $signed({b_q[31], b_q}) - $signed({a_q[31], a_q});
		cb  = $signed({nx_q[31], nx_q}) - $signed({b_q[31], b_q});
		ca  = $signed({ram_rdata[31], ram_rdata}) - $signed({a_q[31], a_q});

		case (op_q)
			OP_HS2: begin
				mul_x = MW'(pgd_pkg::mag({hs_q[32], hs_q}));
				mul_y = pgd_pkg::mag({hs_q[32], hs_q});
			end
			OP_HD2: begin
				mul_x = MW'(pgd_pkg::mag({hd_q[32], hd_q}));
				mul_y = pgd_pkg::mag({hd_q[32], hd_q});
			end
			OP_T: begin
				mul_x = MW'(pgd_pkg::mag({hs_q[32], hs_q}));
				mul_y = pgd_pkg::mag({hd_q[32], hd_q});
			end
			OP_D: begin
				mul_x = dmag_q;
				mul_y = pgd_pkg::mag(hsd);
			end
			OP_M1: begin
				mul_x = hd2_q;
				mul_y = pgd_pkg::mag({ba[32], ba});
			end
			default: begin
				mul_x = hs2_q;
				mul_y = pgd_pkg::mag({cb[32], cb});
			end
		endcase
		mul_start = state_q == S_MS;
		mext      = $signed({1'b0, mul_prod});

		nneg_v    = -n_q;
		nabs      = n_q[MW] ? nneg_v[MW-1:0] : n_q[MW-1:0];
		div_start = (state_q == S_DS) && (dmag_q != '0);

		// rounded quotient to Q16.16 with clipping
		dneg_flag = nneg_q ^ dneg_q;
		qlo       = quo[31:0];
		lim       = dneg_flag ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		if (dz_q) begin
			dsat = 1'b1;
			dval = nzero_q ? 32'd0 : (nneg_q ? pgd_pkg::VAL_MIN : pgd_pkg::VAL_MAX);
		end else if ((|quo[QW-1:32]) || ({1'b0, qlo} > lim)) begin
			dsat = 1'b1;
			dval = dneg_flag ? pgd_pkg::VAL_MIN : pgd_pkg::VAL_MAX;
		end else begin
			dsat = 1'b0;
			dval = dneg_flag ? (32'd0 - qlo) : qlo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_HS2;
			kind_q      <= K_REG;
			np_q        <= 13'd256;
			nc_q        <= 4'd1;
			mask_q      <= 8'd0;
			mode_q      <= 1'b0;
			step_q      <= 31'd65536;
			p_q         <= '0;
			c_q         <= '0;
			rot_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							pgd_pkg::REG_NUM_POINTS: begin
								np_q <= cfg_data[12:0]; p_q <= '0; c_q <= '0;
							end
							pgd_pkg::REG_NUM_COMPONENTS: begin
								nc_q <= cfg_data[3:0]; p_q <= '0; c_q <= '0;
							end
							pgd_pkg::REG_DIFFUSION_MASK: begin
								mask_q <= cfg_data[7:0]; p_q <= '0; c_q <= '0;
							end
							pgd_pkg::REG_SPACING_MODE: begin
								mode_q <= cfg_data[0]; p_q <= '0; c_q <= '0;
							end
							pgd_pkg::REG_UNIFORM_STEP: begin
								step_q <= cfg_data[30:0]; p_q <= '0; c_q <= '0;
							end
							default: begin
							end
						endcase
					end else if (in_acc) begin
						if (c_q == '0) begin
							wc0_q  <= wc1_q;
							wc1_q  <= wc2_q;
							wc2_q  <= in_data.coordinate;
							sp2_q  <= sp1_q;
							sp1_q  <= scur_q;
							scur_q <= newslot;
							if (p_q > PW'(1)) begin
								rot_q <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
							end
							if (p_q == PW'(0)) begin
								fc0_q <= in_data.coordinate;
							end
							if (p_q == PW'(1)) begin
								fc1_q <= in_data.coordinate;
							end
						end
						if (comp_last_in) begin
							c_q      <= '0;
							pbase_q  <= p_q;
							lastpt_q <= lastpt;
							p_q      <= lastpt ? '0 : p_q + PW'(1);
							if (p_q > PW'(1)) begin
								kind_q  <= K_REG;
								state_q <= S_ROW;
							end
						end else begin
							c_q <= c_q + CW'(1);
						end
					end
				end
				S_ROW: begin
					hs_q  <= hs_n;
					hd_q  <= hd_n;
					j_q   <= '0;
					col_q <= 4'd0;
					if (!mode_q) begin
						op_q    <= OP_HS2;
						state_q <= S_MS;
					end else begin
						state_q <= S_RDC;
					end
				end
				S_MS: state_q <= S_MW;
				S_MW: begin
					if (mul_done) begin
						case (op_q)
							OP_HS2: begin
								hs2_q <= mul_prod; op_q <= OP_HD2; state_q <= S_MS;
							end
							OP_HD2: begin
								hd2_q <= mul_prod; op_q <= OP_T; state_q <= S_MS;
							end
							OP_T: begin
								dmag_q <= mul_prod; op_q <= OP_D; state_q <= S_MS;
							end
							OP_D: begin
								dmag_q  <= mul_prod;
								dneg_q  <= hs_q[32] ^ hd_q[32] ^ hsd[33];
								state_q <= S_RDC;
							end
							OP_M1: begin
								n_q     <= ba[32] ? -mext : mext;
								op_q    <= OP_M2;
								state_q <= S_MS;
							end
							default: begin
								n_q     <= n_q + (cb[32] ? -mext : mext);
								state_q <= S_DS;
							end
						endcase
					end
				end
				S_RDC: state_q <= S_GETC;
				S_GETC: begin
					b_q     <= ram_rdata;
					state_q <= S_EMC;
				end
				S_EMC: begin
					if (out_free) begin
						out_q <= '{point_index: 12'(row_pt), column: col_q, value: b_q,
							is_derivative: 1'b0, saturated: 1'b0,
							last_of_run: row_final && j_last && !mbit};
						col_q <= col_q + 4'd1;
						if (mbit) begin
							state_q <= S_RDA;
						end else if (!j_last) begin
							j_q     <= j_q + CW'(1);
							state_q <= S_RDC;
						end else if (row_final) begin
							state_q <= S_IDLE;
						end else begin
							kind_q  <= (kind_q == K_REG) ? K_LAST : K_ZERO;
							state_q <= S_ROW;
						end
					end
				end
				S_RDA: state_q <= S_RDN;
				S_RDN: begin
					a_q     <= ram_rdata;
					state_q <= S_GETN;
				end
				S_GETN: begin
					nx_q <= ram_rdata;
					if (mode_q) begin
						n_q     <= (MW+1)'(ca);
						dmag_q  <= MW'({step_q, 1'b0});
						dneg_q  <= 1'b0;
						state_q <= S_DS;
					end else begin
						op_q    <= OP_M1;
						state_q <= S_MS;
					end
				end
				S_DS: begin
					nneg_q  <= n_q[MW];
					nzero_q <= n_q == '0;
					dz_q    <= dmag_q == '0;
					state_q <= (dmag_q == '0) ? S_EMD : S_DW;
				end
				S_DW: begin
					if (div_done) begin
						state_q <= S_EMD;
					end
				end
				S_EMD: begin
					if (out_free) begin
						out_q <= '{point_index: 12'(row_pt), column: col_q, value: dval,
							is_derivative: 1'b1, saturated: dsat,
							last_of_run: row_final && j_last};
						col_q <= col_q + 4'd1;
						if (!j_last) begin
							j_q     <= j_q + CW'(1);
							state_q <= S_RDC;
						end else if (row_final) begin
							state_q <= S_IDLE;
						end else begin
							kind_q  <= (kind_q == K_REG) ? K_LAST : K_ZERO;
							state_q <= S_ROW;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready = state_q == S_IDLE;
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	pgd_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_data.sample),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pgd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pgd_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (nabs),
		.den    (dmag_q),
		.done   (div_done),
		.quo    (quo)
	);

endmodule

// ----- design/pgd_chk.sv -----
// Port-level checker for the periodic grid derivative, bound to the top level.
// Depends on pgd_pkg for the result beat type.
module pgd_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          cfg_valid,
	input logic          cfg_ready,
	input logic          out_valid,
	input logic          out_ready,
	input pgd_pkg::out_t out_data
);

	// the sample channel opens only while the config channel is open
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready)
		else $error("in_ready without cfg_ready");

	// taking samples again means the pending beat closes the run
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_data.last_of_run)
		else $error("ready while a mid-run beat is pending");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> out_data.is_derivative)
		else $error("saturated flag on a copied value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

endmodule

bind periodic_grid_derivative pgd_chk u_pgd_chk (.*);
